FILE: rtl/lfpid_pkg.sv
`default_nettype none

package lfpid_pkg;

  // Result kinds carried on the output tuser.
  typedef enum logic [2:0] {
    ACT_DRIVE       = 3'd0,
    ACT_PIVOT_RIGHT = 3'd1,
    ACT_PIVOT_LEFT  = 3'd2,
    ACT_STOP        = 3'd3,
    ACT_HOLD        = 3'd4
  } action_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_OUTER_WEIGHT = 3'd3,
    REG_INNER_WEIGHT = 3'd4,
    REG_BASE_SPEED   = 3'd5,
    REG_LOST_TIMEOUT = 3'd6
  } reg_index_t;

  // Input kind carried on the input tuser.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam int DRIVE_LIMIT = 99;
  localparam int SUM_LIMIT   = 200;

  // Reset values of the configuration registers.
  localparam logic [11:0] GAIN_P_RESET       = 12'd1690;
  localparam logic [11:0] GAIN_I_RESET       = 12'd0;
  localparam logic [11:0] GAIN_D_RESET       = 12'd51;
  localparam logic [3:0]  OUTER_WEIGHT_RESET = 4'd4;
  localparam logic [3:0]  INNER_WEIGHT_RESET = 4'd1;
  localparam logic [6:0]  BASE_SPEED_RESET   = 7'd70;
  localparam logic [15:0] LOST_TIMEOUT_RESET = 16'd10000;

endpackage

`default_nettype wire

FILE: rtl/line_follow_pid_steering_unit.sv
`default_nettype none

// Channel  Direction  Handshake           Payload
// in_      slave      in_tvalid/tready    tuser: func; tdata: four sensor bits
// out_     master     out_tvalid/tready   tuser: action; tdata: left, right drive
// cfg_     slave      cfg_valid/ready     cfg_index, cfg_data
//
// One input word can be accepted every cycle unless a stall on the output has
// filled the pipeline. A sensor sample sits in the input register, passes the
// error stage and the multiply stage, and is rounded and saturated into the
// output register. A timer tick gives no result and leaves the pipeline after the
// error stage. Reset clears the control state and the PID state and loads the
// default configuration. A stall on the output holds every occupied stage at
// once while empty stages still fill, so up to four words are held before
// in_tready drops; the configuration port is always ready.

module line_follow_pid_steering_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] outer left, [1] inner left,
                                       // [2] inner right, [3] outer right
  input  wire logic        in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] left_drive, [15:8] right_drive
  output logic [2:0]       out_tuser,  // [2:0] action
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers.
  logic [11:0] gain_p_r, gain_i_r, gain_d_r;
  logic [3:0]  outer_weight_r, inner_weight_r;
  logic [6:0]  base_speed_r;
  logic [15:0] lost_timeout_r;

  // PID and lost-line state.
  logic signed [8:0] error_sum_r, error_sum_nxt;
  logic signed [5:0] last_error_r, last_error_nxt;
  logic              line_lost_r, line_lost_nxt;
  logic [15:0]       lost_ticks_r, lost_ticks_nxt;

  // Pipeline registers.
  logic                 v0_r;
  logic                 s0_func_r;
  logic [3:0]           s0_sens_r;
  logic                 va_r, va_nxt;
  lfpid_pkg::action_t   a_action_r, a_action_nxt;
  logic signed [5:0]    a_err_r, a_err_nxt;
  logic signed [8:0]    a_sum_r;
  logic signed [6:0]    a_diff_r, a_diff_nxt;
  logic                 vb_r;
  lfpid_pkg::action_t   b_action_r;
  logic signed [18:0]   b_p_r, b_p_nxt;
  logic signed [21:0]   b_i_r, b_i_nxt;
  logic signed [19:0]   b_d_r, b_d_nxt;
  logic                 vo_r;
  lfpid_pkg::action_t   o_action_r, o_action_nxt;
  logic signed [7:0]    o_left_r, o_left_nxt, o_right_r, o_right_nxt;

  // Stage advance enables, from the output back to the input.
  logic o_en, b_en, a_en, s0_fire;

  assign o_en    = !vo_r || out_tready;
  assign b_en    = !vb_r || o_en;
  assign a_en    = !va_r || b_en;
  assign s0_fire = v0_r && a_en;

  assign in_tready = !v0_r || a_en;
  assign cfg_ready = 1'b1;

  assign out_tvalid = vo_r;
  assign out_tuser  = o_action_r;
  assign out_tdata  = {o_right_r, o_left_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r       <= lfpid_pkg::GAIN_P_RESET;
      gain_i_r       <= lfpid_pkg::GAIN_I_RESET;
      gain_d_r       <= lfpid_pkg::GAIN_D_RESET;
      outer_weight_r <= lfpid_pkg::OUTER_WEIGHT_RESET;
      inner_weight_r <= lfpid_pkg::INNER_WEIGHT_RESET;
      base_speed_r   <= lfpid_pkg::BASE_SPEED_RESET;
      lost_timeout_r <= lfpid_pkg::LOST_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfpid_pkg::REG_GAIN_P:       gain_p_r       <= cfg_data[11:0];
        lfpid_pkg::REG_GAIN_I:       gain_i_r       <= cfg_data[11:0];
        lfpid_pkg::REG_GAIN_D:       gain_d_r       <= cfg_data[11:0];
        lfpid_pkg::REG_OUTER_WEIGHT: outer_weight_r <= cfg_data[3:0];
        lfpid_pkg::REG_INNER_WEIGHT: inner_weight_r <= cfg_data[3:0];
        lfpid_pkg::REG_BASE_SPEED:   base_speed_r   <= cfg_data[6:0];
        lfpid_pkg::REG_LOST_TIMEOUT: lost_timeout_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tready) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_func_r <= in_tuser;
      s0_sens_r <= in_tdata[3:0];
    end
  end

  // Error stage: classify the word, form the weighted error and update state.
  logic              ol, il, ir, orr;
  logic signed [5:0] ow_s, iw_s;
  logic signed [9:0] sum_raw;
  logic signed [8:0] sum_clamped;

  assign ol  = s0_sens_r[0];
  assign il  = s0_sens_r[1];
  assign ir  = s0_sens_r[2];
  assign orr = s0_sens_r[3];
  assign ow_s = $signed({2'b00, outer_weight_r});
  assign iw_s = $signed({2'b00, inner_weight_r});

  always_comb begin
    a_err_nxt = (orr ? ow_s : 6'sd0) - (ol ? ow_s : 6'sd0)
              + (ir ? iw_s : 6'sd0) - (il ? iw_s : 6'sd0);
    sum_raw   = 10'(error_sum_r) + 10'(a_err_nxt);
    if (sum_raw > 10'(lfpid_pkg::SUM_LIMIT)) begin
      sum_clamped = 9'(lfpid_pkg::SUM_LIMIT);
    end else if (sum_raw < -10'(lfpid_pkg::SUM_LIMIT)) begin
      sum_clamped = -9'(lfpid_pkg::SUM_LIMIT);
    end else begin
      sum_clamped = sum_raw[8:0];
    end
    a_diff_nxt = 7'(a_err_nxt) - 7'(last_error_r);
  end

  always_comb begin
    error_sum_nxt  = error_sum_r;
    last_error_nxt = last_error_r;
    line_lost_nxt  = line_lost_r;
    lost_ticks_nxt = lost_ticks_r;
    va_nxt         = 1'b1;
    a_action_nxt   = lfpid_pkg::ACT_DRIVE;
    priority if (s0_func_r == lfpid_pkg::FUNC_TICK) begin
      va_nxt = 1'b0;
      if (line_lost_r) begin
        if (lost_ticks_r != 16'hFFFF) begin
          lost_ticks_nxt = lost_ticks_r + 16'd1;
        end
      end else begin
        lost_ticks_nxt = '0;
      end
    end else if (ol && il && ir && orr) begin
      line_lost_nxt = 1'b1;
      a_action_nxt  = (lost_ticks_r > lost_timeout_r) ? lfpid_pkg::ACT_STOP
                                                      : lfpid_pkg::ACT_HOLD;
    end else if (!ol && il && ir && orr) begin
      a_action_nxt = lfpid_pkg::ACT_PIVOT_RIGHT;
    end else if (ol && il && ir && !orr) begin
      a_action_nxt = lfpid_pkg::ACT_PIVOT_LEFT;
    end else begin
      line_lost_nxt  = 1'b0;
      error_sum_nxt  = sum_clamped;
      last_error_nxt = a_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
      line_lost_r  <= 1'b0;
      lost_ticks_r <= '0;
      va_r         <= 1'b0;
    end else begin
      if (s0_fire) begin
        error_sum_r  <= error_sum_nxt;
        last_error_r <= last_error_nxt;
        line_lost_r  <= line_lost_nxt;
        lost_ticks_r <= lost_ticks_nxt;
      end
      if (a_en) begin
        va_r <= s0_fire && va_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      a_action_r <= a_action_nxt;
      a_err_r    <= a_err_nxt;
      a_sum_r    <= sum_clamped;
      a_diff_r   <= a_diff_nxt;
    end
  end

  // Multiply stage: the three gain products in parallel.
  always_comb begin
    b_p_nxt = 19'($signed({1'b0, gain_p_r})) * 19'(a_err_r);
    b_i_nxt = 22'($signed({1'b0, gain_i_r})) * 22'(a_sum_r);
    b_d_nxt = 20'($signed({1'b0, gain_d_r})) * 20'(a_diff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (b_en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en && va_r) begin
      b_action_r <= a_action_r;
      b_p_r      <= b_p_nxt;
      b_i_r      <= b_i_nxt;
      b_d_r      <= b_d_nxt;
    end
  end

  // Output: sum, round half away from zero, steer and saturate; 0 unless DRIVE.
  logic signed [22:0] acc;
  logic [22:0]        mag;
  logic [14:0]        rmag;
  logic signed [15:0] r_s, left_s, right_s;

  function automatic logic signed [7:0] sat_drive(input logic signed [15:0] v);
    logic signed [7:0] res;
    if (v > 16'(lfpid_pkg::DRIVE_LIMIT)) begin
      res = 8'(lfpid_pkg::DRIVE_LIMIT);
    end else if (v < -16'(lfpid_pkg::DRIVE_LIMIT)) begin
      res = -8'(lfpid_pkg::DRIVE_LIMIT);
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  always_comb begin
    acc     = 23'(b_p_r) + 23'(b_i_r) + 23'(b_d_r);
    mag     = acc[22] ? 23'(-acc) : 23'(acc);
    rmag    = 15'((mag + 23'd128) >> 8);
    r_s     = acc[22] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    left_s  = $signed({9'b0, base_speed_r}) + r_s;
    right_s = $signed({9'b0, base_speed_r}) - r_s;
    o_action_nxt = b_action_r;
    if (b_action_r == lfpid_pkg::ACT_DRIVE) begin
      o_left_nxt  = sat_drive(left_s);
      o_right_nxt = sat_drive(right_s);
    end else begin
      o_left_nxt  = '0;
      o_right_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (o_en) begin
      vo_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en && vb_r) begin
      o_action_r <= o_action_nxt;
      o_left_r   <= o_left_nxt;
      o_right_r  <= o_right_nxt;
    end
  end

endmodule

`default_nettype wire
